// ===== hdl/flrs_pkg.sv =====
// ----------------------------------------------------------------------------
// flrs_pkg
// Shared types and constants for the fixed-latency request slot model.
// ----------------------------------------------------------------------------
`default_nettype none

package flrs_pkg;

	localparam int SLOTS_DEF       = 4;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int LAT_W  = 16;
	localparam int CD_W   = 17;
	localparam int ADDR_W = 64;
	localparam int TAG_W  = 8;
	localparam int OP_W   = 3;
	localparam int CFG_IDX_W = 1;

	// Request opcodes on the input channel
	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 3'd0,
		OP_READ     = 3'd1,
		OP_WRITE    = 3'd2,
		OP_ALLOC    = 3'd3,
		OP_PREFETCH = 3'd4
	} op_e;

	// Request type as carried in the queue and reported
	typedef enum logic [1:0] {
		RT_READ     = 2'd0,
		RT_WRITE    = 2'd1,
		RT_ALLOC    = 2'd2,
		RT_PREFETCH = 2'd3
	} req_type_e;

	typedef enum logic {
		KIND_DONE = 1'b0,
		KIND_DROP = 1'b1
	} kind_e;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_LAT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_EXTRA = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [TAG_W-1:0]  tag;
		req_type_e         rtype;
	} req_t;

	typedef struct packed {
		kind_e kind;
		req_t  req;
	} result_t;

	typedef struct packed {
		logic [CD_W-1:0] countdown;
		req_t            req;
	} slot_entry_t;

	// Commands to the result buffer
	typedef enum logic [1:0] {
		BUF_NONE   = 2'd0,
		BUF_DIRECT = 2'd1,
		BUF_HOLD   = 2'd2,
		BUF_FLUSH  = 2'd3
	} buf_cmd_e;

	typedef struct packed {
		buf_cmd_e cmd;
		result_t  item;
	} buf_req_t;

	typedef struct packed {
		logic ready;
		logic out_free;
	} buf_status_t;

endpackage

`default_nettype wire

// ===== hdl/flrs_ram.sv =====
// ----------------------------------------------------------------------------
// flrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module flrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/flrs_result_buffer.sv =====
// ----------------------------------------------------------------------------
// flrs_result_buffer
// Output register plus one holding stage, so that the final report of a tick
// can be marked last once the sweep over the slots has ended.
// ----------------------------------------------------------------------------
`default_nettype none

module flrs_result_buffer
	import flrs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire buf_req_t    breq,
	output buf_status_t      bstat,
	output logic             out_valid,
	input  wire logic        out_stall,
	output result_t          out_item,
	output logic             out_last
);

	logic    out_valid_q;
	logic    hold_valid_q;
	result_t hold_q;
	result_t out_item_q;
	logic    out_last_q;

	logic out_free;
	logic load_out;
	logic from_hold;
	logic last_d;
	logic load_hold;
	logic clr_hold;
	logic ready_d;

	assign out_free = !out_valid_q || !out_stall;

	// Decode the command into register loads
	always_comb begin
		load_out  = 1'b0;
		from_hold = 1'b0;
		last_d    = 1'b0;
		load_hold = 1'b0;
		clr_hold  = 1'b0;
		ready_d   = 1'b1;
		case (breq.cmd)
			BUF_NONE: begin
				ready_d = 1'b1;
			end
			BUF_DIRECT: begin
				ready_d  = out_free;
				load_out = out_free;
				last_d   = 1'b1;
			end
			BUF_HOLD: begin
				ready_d = out_free || !hold_valid_q;
				if (hold_valid_q) begin
					load_out  = out_free;
					from_hold = 1'b1;
					load_hold = out_free;
				end else begin
					load_hold = 1'b1;
				end
			end
			BUF_FLUSH: begin
				ready_d = out_free || !hold_valid_q;
				if (hold_valid_q && out_free) begin
					load_out  = 1'b1;
					from_hold = 1'b1;
					last_d    = 1'b1;
					clr_hold  = 1'b1;
				end
			end
			default: begin
				ready_d = 1'b1;
			end
		endcase
	end

	assign bstat.ready    = ready_d;
	assign bstat.out_free = out_free;

	// Hold the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (load_hold) begin
				hold_valid_q <= 1'b1;
			end else if (clr_hold) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_item_q <= from_hold ? hold_q : breq.item;
			out_last_q <= last_d;
		end
		if (load_hold) begin
			hold_q <= breq.item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign out_last  = out_last_q;

	a_direct_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(breq.cmd == BUF_DIRECT) |-> !hold_valid_q)
		else $error("drop report while a completion is still held");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(breq.cmd == BUF_FLUSH && bstat.ready) |=> !hold_valid_q)
		else $error("held report survived the flush");

	a_hold_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_valid_q && breq.cmd == BUF_HOLD && !out_free) |=> hold_valid_q)
		else $error("held report lost while the output was blocked");

endmodule

`default_nettype wire

// ===== hdl/fixed_latency_request_slots.sv =====
// ----------------------------------------------------------------------------
// fixed_latency_request_slots
// Memory timing model: requests queue in a FIFO and are serviced by a set of
// slots, each holding one request for a fixed number of ticks.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries op, address and request_tag.
// A read, write, alloc or prefetch joins the pending queue; if the queue
// is full it is reported at once as a drop (kind 1, last 1).
// A tick (op 0) sweeps the slots in index order, each slot in a read state
// (slot and queue-head memory read) and a process state (modify and write
// back); a flush state then releases the final report. The slot memory has
// a single read port, so the sweep visits one slot at a time. Unknown
// opcodes are taken and ignored.
// Output channel (out_valid/out_stall) gives one completion or drop report
// per transfer; last marks the final report caused by one input item.
// Reports leave through an output register; completions first wait in a holding stage.
// A stall on the output holds the sweep where a report cannot be placed and
// holds in_stall high while the output register is blocked.
// Reset empties the queue and frees every slot; latency registers reset to
// zero and may be written through cfg_we/cfg_index/cfg_wdata while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_latency_request_slots
	import flrs_pkg::*;
#(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LAT_W-1:0]     cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [ADDR_W-1:0]    address,
	input  wire logic [TAG_W-1:0]     request_tag,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      kind,
	output logic [TAG_W-1:0]          done_tag,
	output logic [ADDR_W-1:0]         done_address,
	output logic [1:0]                done_type,
	output logic                      last
);

	localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int QSW = QCW + 1;
	localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int REQ_W  = $bits(req_t);
	localparam int SLOT_W = $bits(slot_entry_t);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_READ  = 2'd1,
		ST_PROC  = 2'd2,
		ST_FLUSH = 2'd3
	} state_t;

	state_t           state_q;
	logic [SIW-1:0]   slot_q;
	logic [SLOTS-1:0] busy_q;
	logic [QIW-1:0]   head_q;
	logic [QCW-1:0]   count_q;
	logic [LAT_W-1:0] access_lat_q;
	logic [LAT_W-1:0] write_extra_q;

	buf_req_t    breq;
	buf_status_t bstat;
	result_t     out_item;

	logic        in_xfer;
	logic        is_req;
	logic        q_full;
	logic        enqueue;
	req_t        new_req;
	logic [QSW-1:0] tail_sum;
	logic [QSW-1:0] tail_wrap;

	logic [REQ_W-1:0]  q_rdata;
	logic [SLOT_W-1:0] s_rdata;
	logic [SLOT_W-1:0] s_wdata;
	req_t              q_head;
	slot_entry_t       s_cur;
	logic              busy_cur;
	logic [CD_W-1:0]   cd_dec;
	logic [CD_W-1:0]   delay_sum;
	logic [CD_W-1:0]   delay;
	logic              completes;
	logic              takes;
	logic              advance_proc;
	logic              s_we;

	// Classify the incoming item
	always_comb begin
		case (op_e'(op))
			OP_READ, OP_WRITE, OP_ALLOC, OP_PREFETCH: is_req = 1'b1;
			default:                                  is_req = 1'b0;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE) || !bstat.out_free;
	assign in_xfer  = in_valid && !in_stall;
	assign q_full   = (count_q == QCW'(QUEUE_DEPTH));
	assign enqueue  = in_xfer && is_req && !q_full;

	assign new_req.address = address;
	assign new_req.tag     = request_tag;
	assign new_req.rtype   = req_type_e'(2'(op - 3'd1));

	// Tail position: head plus count, wrapped once
	assign tail_sum  = QSW'(head_q) + QSW'(count_q);
	assign tail_wrap = (tail_sum >= QSW'(QUEUE_DEPTH)) ? tail_sum - QSW'(QUEUE_DEPTH)
		: tail_sum;

	flrs_ram #(
		.WIDTH (REQ_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (enqueue),
		.waddr (tail_wrap[QIW-1:0]),
		.wdata (new_req),
		.raddr (head_q),
		.rdata (q_rdata)
	);

	flrs_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (slot_q),
		.wdata (s_wdata),
		.raddr (slot_q),
		.rdata (s_rdata)
	);

	// Modify the visited slot
	always_comb begin
		q_head    = req_t'(q_rdata);
		s_cur     = slot_entry_t'(s_rdata);
		busy_cur  = busy_q[slot_q];
		cd_dec    = s_cur.countdown - CD_W'(s_cur.countdown != '0);
		delay_sum = CD_W'(access_lat_q) +
			((q_head.rtype == RT_WRITE) ? CD_W'(write_extra_q) : '0);
		delay     = (delay_sum == '0) ? CD_W'(1) : delay_sum;
		completes = busy_cur && (cd_dec == '0);
		takes     = !busy_cur && (count_q != '0);
		s_wdata   = busy_cur ? {cd_dec, s_cur.req} : {delay, q_head};
	end

	// Drive the result buffer
	always_comb begin
		breq.cmd       = BUF_NONE;
		breq.item.kind = KIND_DONE;
		breq.item.req  = s_cur.req;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && is_req && q_full) begin
					breq.cmd       = BUF_DIRECT;
					breq.item.kind = KIND_DROP;
					breq.item.req  = new_req;
				end
			end
			ST_PROC: begin
				if (completes) begin
					breq.cmd = BUF_HOLD;
				end
			end
			ST_FLUSH: begin
				breq.cmd = BUF_FLUSH;
			end
			default: begin
				breq.cmd = BUF_NONE;
			end
		endcase
	end

	assign advance_proc = (state_q == ST_PROC) && bstat.ready;
	assign s_we         = advance_proc && (busy_cur || takes);

	// Hold state, sweep position, busy flags and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			busy_q  <= '0;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && op == OP_TICK) begin
						slot_q  <= '0;
						state_q <= ST_READ;
					end
					if (enqueue) begin
						count_q <= count_q + QCW'(1);
					end
				end
				ST_READ: begin
					state_q <= ST_PROC;
				end
				ST_PROC: begin
					if (advance_proc) begin
						if (completes) begin
							busy_q[slot_q] <= 1'b0;
						end else if (takes) begin
							busy_q[slot_q] <= 1'b1;
							head_q  <= (head_q == QIW'(QUEUE_DEPTH - 1)) ? '0
								: head_q + QIW'(1);
							count_q <= count_q - QCW'(1);
						end
						if (slot_q == SIW'(SLOTS - 1)) begin
							state_q <= ST_FLUSH;
						end else begin
							slot_q  <= slot_q + SIW'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_FLUSH: begin
					if (bstat.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latency registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_lat_q  <= '0;
			write_extra_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACCESS_LAT:  access_lat_q  <= cfg_wdata;
				CFG_WRITE_EXTRA: write_extra_q <= cfg_wdata;
				default:         access_lat_q  <= access_lat_q;
			endcase
		end
	end

	flrs_result_buffer u_result_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.breq      (breq),
		.bstat     (bstat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.out_last  (last)
	);

	assign kind         = out_item.kind;
	assign done_tag     = out_item.req.tag;
	assign done_address = out_item.req.address;
	assign done_type    = out_item.req.rtype;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_tick_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && op == OP_TICK) |=> (state_q == ST_READ && slot_q == '0))
		else $error("tick did not start the slot sweep");

	a_take_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_proc && takes) |=> (count_q == $past(count_q) - QCW'(1)))
		else $error("slot took a request without popping the queue");

endmodule

`default_nettype wire

// ===== dv/fixed_latency_request_slots_tb.sv =====
// ----------------------------------------------------------------------------
// fixed_latency_request_slots_tb
// Self-checking bench for the request slot timing model. A queue of requests
// and ticks feeds a valid/stall driver. A slot and queue predictor runs
// beside it and forms the completion and drop reports. A monitor checks each
// report transfer against the oldest prediction. Latency settings change
// between phases. Both sides idle at random, apart from the closing phase.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_latency_request_slots_tb
	import flrs_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS          = SLOTS_DEF;
	localparam int QUEUE_DEPTH    = QUEUE_DEPTH_DEF;
	localparam int SETTLE_CYCLES  = 20;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 150;
	localparam int DRAIN_TICKS    = 32;

	// Opcodes outside the defined set, taken and ignored by the block
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]   code;
		logic [ADDR_W-1:0] addr;
		logic [TAG_W-1:0]  tag;
	} stim_t;

	typedef struct packed {
		kind_e             kind;
		logic [TAG_W-1:0]  tag;
		logic [ADDR_W-1:0] addr;
		req_type_e         rtype;
		logic              last;
	} report_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = CFG_ACCESS_LAT;
	logic [LAT_W-1:0]     cfg_wdata   = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      op          = OP_TICK;
	logic [ADDR_W-1:0]    address     = '0;
	logic [TAG_W-1:0]     request_tag = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic                 kind;
	logic [TAG_W-1:0]     done_tag;
	logic [ADDR_W-1:0]    done_address;
	logic [1:0]           done_type;
	logic                 last;

	fixed_latency_request_slots #(
		.SLOTS       (SLOTS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.address      (address),
		.request_tag  (request_tag),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.done_tag     (done_tag),
		.done_address (done_address),
		.done_type    (done_type),
		.last         (last)
	);

	// Stimulus and prediction stores
	stim_t   request_stream [$];
	report_t expected_reports [$];

	// Predicted queue and slot state
	req_t            pending_ring [QUEUE_DEPTH];
	int unsigned     ring_count;
	int unsigned     ring_head;
	bit              slot_active [SLOTS];
	logic [CD_W-1:0] slot_ticks_left [SLOTS];
	req_t            slot_held [SLOTS];
	logic [LAT_W-1:0] lat_access;
	logic [LAT_W-1:0] lat_write_extra;

	// Bench control
	bit      no_idle = 1'b0;
	int      send_gap = 0;
	int      stall_left = 0;
	bit      long_hold_done = 1'b0;
	int      report_transfers = 0;
	int      report_mismatches = 0;
	int      quiet_cycles = 0;
	stim_t   next_item;
	report_t wanted;
	bit      wrong;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the predicted slots and queue by one accepted item
	task automatic advance_slot_model(input logic [OP_W-1:0] code,
			input logic [ADDR_W-1:0] addr, input logic [TAG_W-1:0] tag);
		report_t         held;
		bit              have_held;
		req_t            fresh;
		logic [CD_W-1:0] delay;
		int              s;
		have_held = 1'b0;
		held = '0;
		fresh = '0;
		if (code == OP_TICK) begin
			for (s = 0; s < SLOTS; s++) begin
				if (slot_active[s]) begin
					if (slot_ticks_left[s] != '0)
						slot_ticks_left[s] = slot_ticks_left[s] - 1'b1;
					if (slot_ticks_left[s] == '0) begin
						slot_active[s] = 1'b0;
						if (have_held)
							expected_reports.push_back(held);
						held.kind  = KIND_DONE;
						held.tag   = slot_held[s].tag;
						held.addr  = slot_held[s].address;
						held.rtype = slot_held[s].rtype;
						held.last  = 1'b0;
						have_held  = 1'b1;
					end
				end else if (ring_count > 0) begin
					fresh = pending_ring[ring_head];
					ring_head = (ring_head + 1) % QUEUE_DEPTH;
					ring_count--;
					delay = {1'b0, lat_access};
					if (fresh.rtype == RT_WRITE)
						delay = delay + {1'b0, lat_write_extra};
					if (delay == '0)
						delay = CD_W'(1);
					slot_held[s] = fresh;
					slot_ticks_left[s] = delay;
					slot_active[s] = 1'b1;
				end
			end
		end else if (code <= OP_PREFETCH) begin
			fresh.address = addr;
			fresh.tag = tag;
			case (code)
				OP_READ:  fresh.rtype = RT_READ;
				OP_WRITE: fresh.rtype = RT_WRITE;
				OP_ALLOC: fresh.rtype = RT_ALLOC;
				default:  fresh.rtype = RT_PREFETCH;
			endcase
			if (ring_count >= QUEUE_DEPTH) begin
				held.kind  = KIND_DROP;
				held.tag   = tag;
				held.addr  = addr;
				held.rtype = fresh.rtype;
				have_held  = 1'b1;
			end else begin
				pending_ring[(ring_head + ring_count) % QUEUE_DEPTH] = fresh;
				ring_count++;
			end
		end
		// Mark the final report of this item
		if (have_held) begin
			held.last = 1'b1;
			expected_reports.push_back(held);
		end
	endtask

	// Driver: offer items from the stream, hold them while stalled
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				advance_slot_model(op, address, request_tag);
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (request_stream.size() != 0 &&
						(no_idle || $urandom_range(0, 7) != 0)) begin
					next_item = request_stream.pop_front();
					in_valid    <= 1'b1;
					op          <= next_item.code;
					address     <= next_item.addr;
					request_tag <= next_item.tag;
				end else if (request_stream.size() != 0) begin
					in_valid <= 1'b0;
					send_gap <= $urandom_range(0, 2);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: short random stalls, and one long hold-off to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!long_hold_done && report_transfers >= 40) begin
			out_stall <= 1'b1;
			stall_left <= HOLD_CYCLES - 1;
			long_hold_done <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: compare each report transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			report_transfers <= report_transfers + 1;
			if (expected_reports.size() == 0) begin
				if (report_mismatches < 10)
					$display("%t unexpected report: kind %0d tag %h addr %h %s %0d %s %0d",
						$realtime, kind, done_tag, done_address, "type", done_type,
						"last", last);
				report_mismatches++;
			end else begin
				wanted = expected_reports.pop_front();
				wrong = (kind !== wanted.kind) || (done_tag !== wanted.tag) ||
					(done_address !== wanted.addr) || (done_type !== wanted.rtype) ||
					(last !== wanted.last);
				if (wrong) begin
					if (report_mismatches < 10) begin
						$display("%t report mismatch: expected kind %0d tag %h addr %h",
							$realtime, wanted.kind, wanted.tag, wanted.addr);
						$display("    expected type %0d last %0d",
							wanted.rtype, wanted.last);
						$display("    got kind %0d tag %h addr %h type %0d last %0d",
							kind, done_tag, done_address, done_type, last);
					end
					report_mismatches++;
				end
			end
		end
	end

	// Watchdog: stop when nothing has transferred for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("fixed_latency_request_slots_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [ADDR_W-1:0] random_address();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic push_item(input logic [OP_W-1:0] code, input logic [ADDR_W-1:0] addr,
			input logic [TAG_W-1:0] tag);
		stim_t it;
		it.code = code;
		it.addr = addr;
		it.tag = tag;
		request_stream.push_back(it);
	endtask

	// Write both latency registers while the block is idle
	task automatic write_latencies(input logic [LAT_W-1:0] acc, input logic [LAT_W-1:0] extra);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ACCESS_LAT;
		cfg_wdata <= acc;
		@(posedge clk);
		cfg_index <= CFG_WRITE_EXTRA;
		cfg_wdata <= extra;
		@(posedge clk);
		cfg_we <= 1'b0;
		lat_access = acc;
		lat_write_extra = extra;
	endtask

	// Runs of requests, which can overflow the queue, mix at random with runs of ticks
	task automatic queue_random_traffic(input int count);
		int              sent;
		int              run;
		int              k;
		logic [OP_W-1:0] code;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) < 5) begin
				run = $urandom_range(1, 20);
				for (k = 0; k < run; k++) begin
					if ($urandom_range(0, 24) == 0)
						code = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
					else
						code = OP_W'($urandom_range(OP_READ, OP_PREFETCH));
					push_item(code, random_address(), TAG_W'($urandom_range(0, 255)));
				end
			end else begin
				run = $urandom_range(1, 12);
				for (k = 0; k < run; k++)
					push_item(OP_TICK, random_address(), TAG_W'($urandom_range(0, 255)));
			end
			sent += run;
		end
	endtask

	task automatic queue_drain_ticks();
		int k;
		for (k = 0; k < DRAIN_TICKS; k++)
			push_item(OP_TICK, random_address(), TAG_W'($urandom_range(0, 255)));
	endtask

	// Wait for the stream to empty and every report to arrive, then let a sweep finish
	task automatic settle_phase();
		do
			@(negedge clk);
		while (request_stream.size() != 0 || in_valid || expected_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int k;
		int p;
		logic [LAT_W-1:0] phase_acc [4];
		logic [LAT_W-1:0] phase_extra [4];

		ring_count = 0;
		ring_head = 0;
		lat_access = '0;
		lat_write_extra = '0;
		for (k = 0; k < SLOTS; k++) begin
			slot_active[k] = 1'b0;
			slot_ticks_left[k] = '0;
			slot_held[k] = '0;
		end
		for (k = 0; k < QUEUE_DEPTH; k++)
			pending_ring[k] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: quiet tick, ignored opcodes, each request type, full queue
		write_latencies('0, '0);
		push_item(OP_TICK, '1, 8'hFF);
		push_item(OP_UNUSED_LO, '1, 8'hFF);
		push_item(OP_UNUSED_HI, '0, 8'h00);
		push_item(OP_READ, '0, 8'h00);
		push_item(OP_WRITE, '1, 8'hFF);
		push_item(OP_ALLOC, 64'hA5A5_A5A5_A5A5_A5A5, 8'h5A);
		push_item(OP_PREFETCH, 64'h5A5A_5A5A_5A5A_5A5A, 8'hA5);
		push_item(OP_TICK, '0, 8'h00);
		push_item(OP_TICK, '0, 8'h00);
		for (k = 0; k <= QUEUE_DEPTH; k++)
			push_item(OP_W'(OP_READ + (k % 4)), random_address(),
				TAG_W'($urandom_range(0, 255)));
		settle_phase();

		// Random phases over small latency settings
		phase_acc[0] = 16'd1;  phase_extra[0] = 16'd0;
		phase_acc[1] = 16'd0;  phase_extra[1] = 16'd3;
		phase_acc[2] = 16'd4;  phase_extra[2] = 16'd2;
		phase_acc[3] = LAT_W'($urandom_range(0, 4));
		phase_extra[3] = LAT_W'($urandom_range(0, 3));
		for (p = 0; p < 4; p++) begin
			write_latencies(phase_acc[p], phase_extra[p]);
			queue_random_traffic(75);
			if (p == 3)
				queue_drain_ticks();
			settle_phase();
		end

		// Closing phase with both sides flowing freely
		@(posedge clk);
		no_idle <= 1'b1;
		write_latencies(16'd2, 16'd1);
		queue_random_traffic(60);
		queue_drain_ticks();
		settle_phase();

		if (report_mismatches == 0 && expected_reports.size() == 0)
			$display("fixed_latency_request_slots_tb passed");
		else
			$display("fixed_latency_request_slots_tb failed");
		$finish;
	end

endmodule

`default_nettype wire
